// ----- hdl/rfsw_pkg.sv -----
// ----------------------------------------------------------------------------
// rfsw_pkg
// Types and constants of the remote-switch frame pulse encoder.
// ----------------------------------------------------------------------------
package rfsw_pkg;

  localparam int IdW       = 24;   // width of the switch_id field
  localparam int TickW     = 16;   // width of every duration register
  localparam int CfgAddrW  = 2;
  localparam int InDataW   = 32;   // switch_id, single_unit, turn_on, unit_bit, padding
  localparam int OutDataW  = 8;    // pin_level, busy_res, padding

  typedef logic [TickW-1:0] ticks_t;
  typedef logic [5:0]       sym_pos_t;
  typedef logic [1:0]       phase_t;
  typedef logic [1:0]       repeat_t;

  // Command codes carried on in_tuser.
  localparam logic CmdTick = 1'b0;
  localparam logic CmdSend = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [CfgAddrW-1:0] RegShort = 2'd0;
  localparam logic [CfgAddrW-1:0] RegLong  = 2'd1;
  localparam logic [CfgAddrW-1:0] RegStart = 2'd2;
  localparam logic [CfgAddrW-1:0] RegEnd   = 2'd3;

  localparam ticks_t ShortReset = 16'd260;
  localparam ticks_t LongReset  = 16'd1300;
  localparam ticks_t StartReset = 16'd2600;
  localparam ticks_t EndReset   = 16'd10400;

  // Symbol positions: 0 is the start pulse, 1..32 the data symbols, 33 the end pulse.
  localparam sym_pos_t StartPos = 6'd0;
  localparam sym_pos_t EndPos   = 6'd33;

  // Data symbol indexes (symbol position minus one).
  localparam logic [4:0] LastIdSym = 5'd25;
  localparam logic [4:0] GroupSym  = 5'd26;
  localparam logic [4:0] StateSym  = 5'd27;
  localparam logic [4:0] UnitSym   = 5'd31;

  // Frames still to play after the first one.
  localparam repeat_t RepeatsAfterFirst = 2'd2;

  // A programmed duration of zero behaves as one tick.
  function automatic ticks_t at_least_one(input ticks_t v);
    return (v == '0) ? ticks_t'(1) : v;
  endfunction

endpackage

// ----- hdl/rf_switch_frame_pulse_encoder.sv -----
// ----------------------------------------------------------------------------
// rf_switch_frame_pulse_encoder
// Plays a latched switch command three times as an OOK pulse frame, one
// tick item per timing unit.
// ----------------------------------------------------------------------------
// Every input item, tick or send request, yields exactly one result, which
// is registered and presented in the cycle after the item is taken;
// with out_tready held high the block takes one item per clock.
// A result waiting on a stalled output holds off only the next input. The
// frame timing counts tick items, not clocks: a segment of N ticks needs N
// tick items. Duration registers take effect at the next segment loaded and
// a send request is ignored while a frame sequence is still playing.
module rf_switch_frame_pulse_encoder #(
  parameter int ID_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // switch_id[23:0], single_unit[24], turn_on[25], unit_bit[26], zero padding
  input  logic [rfsw_pkg::InDataW-1:0]         in_tdata,
  // command[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pin_level[0], busy_res[1], zero padding
  output logic [rfsw_pkg::OutDataW-1:0]        out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [rfsw_pkg::CfgAddrW-1:0]        cfg_addr,
  input  logic [rfsw_pkg::TickW-1:0]           cfg_wdata
);
  import rfsw_pkg::*;

  // Only the id bits that can actually be sent are kept.
  localparam int HeldW = (ID_BITS < IdW) ? ID_BITS : IdW;

  ticks_t short_r, long_r, start_r, end_r;

  logic             active_r, active_nxt;
  repeat_t          repeat_r, repeat_nxt;
  sym_pos_t         sym_r, sym_nxt;
  phase_t           phase_r, phase_nxt;
  ticks_t           tick_r, tick_nxt;
  logic [HeldW-1:0] held_id_r, held_id_nxt;
  logic [2:0]       flags_r, flags_nxt;

  logic             out_valid_r;
  logic             pin_r, busy_r;
  logic             res_pin, res_busy;

  logic             accept;
  logic [IdW-1:0]   in_switch_id;
  logic             load_seg;
  logic             last_phase;
  logic             seg_bit;

  function automatic logic data_bit(input sym_pos_t sym, input logic [HeldW-1:0] id,
                                    input logic [2:0] flags);
    logic [4:0]       d;
    logic [4:0]       shamt;
    logic [HeldW-1:0] shifted;
    logic             b;
    d       = 5'(sym - 6'd1);
    shamt   = LastIdSym - d;
    shifted = id >> shamt;
    case (d) inside
      [5'd0:LastIdSym]: b = shifted[0];
      GroupSym:         b = ~flags[0];
      StateSym:         b = flags[1];
      UnitSym:          b = flags[2];
      default:          b = 1'b0;
    endcase
    return b;
  endfunction

  assign in_switch_id = in_tdata[IdW-1:0];
  assign in_tready    = !out_valid_r || out_tready;
  assign accept       = in_tvalid && in_tready;
  assign seg_bit      = data_bit(sym_nxt, held_id_r, flags_r);

  always_comb begin
    active_nxt  = active_r;
    repeat_nxt  = repeat_r;
    sym_nxt     = sym_r;
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    held_id_nxt = held_id_r;
    flags_nxt   = flags_r;
    load_seg    = 1'b0;
    res_pin     = 1'b0;
    res_busy    = 1'b0;
    if ((sym_r == StartPos) || (sym_r >= EndPos)) begin
      last_phase = (phase_r >= 2'd1);
    end else begin
      last_phase = (phase_r == 2'd3);
    end

    if (in_tuser == CmdSend) begin
      if (!active_r) begin
        held_id_nxt = in_switch_id[HeldW-1:0];
        flags_nxt   = in_tdata[IdW+2:IdW];
        active_nxt  = 1'b1;
        repeat_nxt  = RepeatsAfterFirst;
        sym_nxt     = StartPos;
        phase_nxt   = 2'd0;
        load_seg    = 1'b1;
        res_pin     = 1'b1;
      end else begin
        res_pin = ~phase_r[0];
      end
      res_busy = 1'b1;
    end else if (active_r) begin
      res_pin  = ~phase_r[0];
      res_busy = 1'b1;
      if (tick_r <= ticks_t'(1)) begin
        if (!last_phase) begin
          phase_nxt = phase_r + 2'd1;
          load_seg  = 1'b1;
        end else begin
          phase_nxt = 2'd0;
          if (sym_r >= EndPos) begin
            sym_nxt = StartPos;
            if (repeat_r == '0) begin
              active_nxt = 1'b0;
              tick_nxt   = '0;
            end else begin
              repeat_nxt = repeat_r - 2'd1;
              load_seg   = 1'b1;
            end
          end else begin
            sym_nxt  = sym_r + 6'd1;
            load_seg = 1'b1;
          end
        end
      end else begin
        tick_nxt = tick_r - ticks_t'(1);
      end
    end

    // New segment length: high parts use short_r, start/end gaps start_r/end_r;
    // a data gap is long when its bit differs from the pulse half, else short.
    if (load_seg) begin
      if (!phase_nxt[0]) begin
        tick_nxt = at_least_one(short_r);
      end else if (sym_nxt == StartPos) begin
        tick_nxt = at_least_one(start_r);
      end else if (sym_nxt >= EndPos) begin
        tick_nxt = at_least_one(end_r);
      end else if (seg_bit != phase_nxt[1]) begin
        tick_nxt = at_least_one(long_r);
      end else begin
        tick_nxt = at_least_one(short_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= ShortReset;
      long_r  <= LongReset;
      start_r <= StartReset;
      end_r   <= EndReset;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        RegShort: short_r <= cfg_wdata;
        RegLong:  long_r  <= cfg_wdata;
        RegStart: start_r <= cfg_wdata;
        RegEnd:   end_r   <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      repeat_r  <= '0;
      sym_r     <= StartPos;
      phase_r   <= '0;
      tick_r    <= '0;
      held_id_r <= '0;
      flags_r   <= '0;
    end else if (accept) begin
      active_r  <= active_nxt;
      repeat_r  <= repeat_nxt;
      sym_r     <= sym_nxt;
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      held_id_r <= held_id_nxt;
      flags_r   <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_r  <= res_pin;
      busy_r <= res_busy;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-2){1'b0}}, busy_r, pin_r};

`ifndef SYNTHESIS
  a_idle_no_repeats : assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (repeat_r == '0))
    else $error("repeat count left over while idle");

  a_idle_at_frame_start : assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (sym_r == StartPos && phase_r == '0))
    else $error("symbol position or phase not cleared while idle");

  a_active_tick_loaded : assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (tick_r != '0))
    else $error("segment counter empty while sending");

  a_sym_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    sym_r <= EndPos)
    else $error("symbol position beyond the end pulse");

  a_busy_when_pin_high : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pin_r) |-> busy_r)
    else $error("pin driven high while not busy");
`endif

endmodule
